/* sv/psl_pkg.sv */
// Shared types and constants for the permutation swap lower bound block.
package psl_pkg;

  // Default capacity of the token store.
  localparam int unsigned MaxNodesDefault = 16;

  // Fixed field widths of the beats.
  localparam int unsigned TokW   = 4;
  localparam int unsigned TotW   = 7;
  localparam int unsigned DmaxW  = 3;
  localparam int unsigned CycW   = 4;
  localparam int unsigned BoundW = 6;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_OUTER,
    S_MARK,
    S_FOLLOW,
    S_PAR,
    S_PDRAIN,
    S_DONE
  } psl_state_e;

  // Running totals from the loader, seen by the sequencer.
  typedef struct packed {
    logic [TotW-1:0]  dist_sum;
    logic [DmaxW-1:0] dist_max;
    logic             bad;
  } psl_acc_t;

  // One finished result.
  typedef struct packed {
    logic [TotW-1:0]   total_hamming;
    logic [DmaxW-1:0]  max_hamming;
    logic [CycW-1:0]   cycle_bound;
    logic              inversion_parity;
    logic [BoundW-1:0] swap_bound;
    logic              bad_input;
  } psl_res_t;

endpackage

/* sv/permutation_swap_lower_bound_core.sv */
// Top level of the permutation swap lower bound block.
//
// Input beats carry one token each, in node order; the beat with last_token_i
// set closes the permutation. Non-closing beats are taken one per cycle and
// fold their Hamming distance into running totals as they arrive. After the
// closing beat the block drops in_ready_o and runs its sequencer over the
// token store: a check step, a cycle walk (a mark and a follow step per node,
// one outer step per node index and a final one), and a pairwise inversion
// scan on the two-port store with a final drain step. With a bad input the
// sequencer skips the walk and the scan. One result beat leaves through an
// output register. The next permutation may load while that beat waits; if
// the receiver still stalls when the following result is ready, the
// sequencer holds and in_ready_o stays low.
// Reset empties the loader, drops the output valid flag and idles the
// sequencer; the token store needs no clearing.
module permutation_swap_lower_bound_core #(
  parameter int unsigned MAX_NODES = psl_pkg::MaxNodesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [psl_pkg::TokW-1:0]    token_i,
  input  logic                        last_token_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [psl_pkg::TotW-1:0]    total_hamming_o,
  output logic [psl_pkg::DmaxW-1:0]   max_hamming_o,
  output logic [psl_pkg::CycW-1:0]    cycle_bound_o,
  output logic                        inversion_parity_o,
  output logic [psl_pkg::BoundW-1:0]  swap_bound_o,
  output logic                        bad_input_o
);
  import psl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic          beat;
  logic          idle;
  logic          clear;
  logic          res_vld;
  logic          res_free;
  logic [CW-1:0] count;
  psl_acc_t      acc;
  psl_res_t      res;
  psl_res_t      out_q;
  logic          out_vld_q, out_vld_d;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_a_addr;
  logic [IW-1:0] rd_b_addr;
  logic [TokW-1:0] rd_a_data;
  logic [TokW-1:0] rd_b_data;

  assign in_ready_o = idle;
  assign beat       = in_valid_i && idle;
  assign res_free   = !out_vld_q || out_ready_i;

  psl_load #(.MaxNodes(MAX_NODES)) u_load (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .token_i   (token_i),
    .clear_i   (clear),
    .count_o   (count),
    .acc_o     (acc),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr)
  );

  psl_tstore #(.Depth(MAX_NODES)) u_tstore (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (token_i),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

  psl_seq #(.MaxNodes(MAX_NODES)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (beat && last_token_i),
    .count_i     (count),
    .acc_i       (acc),
    .res_free_i  (res_free),
    .rd_a_data_i (rd_a_data),
    .rd_b_data_i (rd_b_data),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr),
    .idle_o      (idle),
    .clear_o     (clear),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  // Output register valid flag.
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_vld) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Output payload, loaded when a result is handed over.
  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign total_hamming_o    = out_q.total_hamming;
  assign max_hamming_o      = out_q.max_hamming;
  assign cycle_bound_o      = out_q.cycle_bound;
  assign inversion_parity_o = out_q.inversion_parity;
  assign swap_bound_o       = out_q.swap_bound;
  assign bad_input_o        = out_q.bad_input;

endmodule

/* sv/psl_tstore.sv */
// Token store: one write port and two registered read ports.
module psl_tstore #(
  parameter int unsigned Depth = psl_pkg::MaxNodesDefault
) (
  input  logic                                         clk_i,
  input  logic                                         wr_en_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0]   wr_addr_i,
  input  logic [psl_pkg::TokW-1:0]                     wr_data_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0]   rd_a_addr_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0]   rd_b_addr_i,
  output logic [psl_pkg::TokW-1:0]                     rd_a_data_o,
  output logic [psl_pkg::TokW-1:0]                     rd_b_data_o
);
  import psl_pkg::*;

  logic [TokW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk_i) begin
    rd_a_data_o <= mem_q[rd_a_addr_i];
    rd_b_data_o <= mem_q[rd_b_addr_i];
  end

endmodule

/* sv/psl_load.sv */
// Loader: counts nodes, accumulates Hamming distances and tracks errors.
module psl_load #(
  parameter int unsigned MaxNodes = psl_pkg::MaxNodesDefault
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            beat_i,
  input  logic [psl_pkg::TokW-1:0]                        token_i,
  input  logic                                            clear_i,
  output logic [$clog2(MaxNodes + 1)-1:0]                 count_o,
  output psl_pkg::psl_acc_t                               acc_o,
  output logic                                            wr_en_o,
  output logic [(MaxNodes > 1 ? $clog2(MaxNodes) : 1)-1:0] wr_addr_o
);
  import psl_pkg::*;

  localparam int unsigned CW = $clog2(MaxNodes + 1);
  localparam int unsigned IW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned XW = (IW > TokW) ? IW : TokW;
  localparam int unsigned MW = (CW > TokW) ? CW : TokW;

  logic [CW-1:0]    count_q, count_d;
  logic [TotW-1:0]  sum_q, sum_d;
  logic [DmaxW-1:0] dmax_q, dmax_d;
  logic [TokW-1:0]  maxtok_q, maxtok_d;
  logic             err_q, err_d;
  logic             store;
  logic [XW-1:0]    diff;
  logic [3:0]       node_dist;
  logic [7:0]       sum_w;
  logic [DmaxW-1:0] dist_cl;

  assign store = beat_i && (count_q < CW'(MaxNodes));

  // Hamming distance between the node index and its token.
  always_comb begin
    node_dist = '0;
    diff = XW'(count_q[IW-1:0]) ^ XW'(token_i);
    for (int b = 0; b < XW; b++) begin
      node_dist = node_dist + 4'(diff[b]);
    end
  end

  // Saturating accumulation and the next register values.
  always_comb begin
    sum_w    = 8'(sum_q) + 8'(node_dist);
    dist_cl  = (node_dist > 4'd7) ? 3'd7 : node_dist[DmaxW-1:0];
    count_d  = count_q;
    sum_d    = sum_q;
    dmax_d   = dmax_q;
    maxtok_d = maxtok_q;
    err_d    = err_q;
    if (clear_i) begin
      count_d  = '0;
      sum_d    = '0;
      dmax_d   = '0;
      maxtok_d = '0;
      err_d    = 1'b0;
    end else if (store) begin
      count_d  = count_q + CW'(1);
      sum_d    = (sum_w > 8'd127) ? 7'd127 : sum_w[TotW-1:0];
      dmax_d   = (dist_cl > dmax_q) ? dist_cl : dmax_q;
      maxtok_d = (token_i > maxtok_q) ? token_i : maxtok_q;
    end else if (beat_i) begin
      err_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      dmax_q   <= '0;
      maxtok_q <= '0;
      err_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      sum_q    <= sum_d;
      dmax_q   <= dmax_d;
      maxtok_q <= maxtok_d;
      err_q    <= err_d;
    end
  end

  // A stored token not below the node count is out of range.
  assign acc_o.dist_sum = sum_q;
  assign acc_o.dist_max = dmax_q;
  assign acc_o.bad      = err_q || (MW'(maxtok_q) >= MW'(count_q));
  assign count_o        = count_q;
  assign wr_en_o        = store;
  assign wr_addr_o      = count_q[IW-1:0];

endmodule

/* sv/psl_seq.sv */
// Sequencer: cycle walk and pairwise inversion parity over the token store.
module psl_seq #(
  parameter int unsigned MaxNodes = psl_pkg::MaxNodesDefault
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  input  logic [$clog2(MaxNodes + 1)-1:0]                  count_i,
  input  psl_pkg::psl_acc_t                                acc_i,
  input  logic                                             res_free_i,
  input  logic [psl_pkg::TokW-1:0]                         rd_a_data_i,
  input  logic [psl_pkg::TokW-1:0]                         rd_b_data_i,
  output logic [(MaxNodes > 1 ? $clog2(MaxNodes) : 1)-1:0] rd_a_addr_o,
  output logic [(MaxNodes > 1 ? $clog2(MaxNodes) : 1)-1:0] rd_b_addr_o,
  output logic                                             idle_o,
  output logic                                             clear_o,
  output logic                                             res_vld_o,
  output psl_pkg::psl_res_t                                res_o
);
  import psl_pkg::*;

  localparam int unsigned CW = $clog2(MaxNodes + 1);
  localparam int unsigned IW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned XW = (IW > TokW) ? IW : TokW;
  localparam int unsigned SW = (CW > CycW) ? CW : CycW;

  psl_state_e          state_q, state_d;
  logic [MaxNodes-1:0] visited_q, visited_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       cyc_q, cyc_d;
  logic [CW-1:0]       pi_q, pi_d;
  logic [CW-1:0]       pj_q, pj_d;
  logic [IW-1:0]       cur_q, cur_d;
  logic                par_q, par_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [XW-1:0]       t_ext;
  logic [IW-1:0]       t_idx;
  logic [SW-1:0]       diff_w;
  logic [CycW-1:0]     cyc_bound;
  logic [7:0]          half;
  logic [7:0]          bound_a;
  logic [7:0]          bound_b;
  logic [7:0]          bound_c;

  // The token just read names the next node of the chain.
  assign t_ext = XW'(rd_a_data_i);
  assign t_idx = t_ext[IW-1:0];

  // Next state, walk counters and the shared compare.
  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    i_d         = i_q;
    cyc_d       = cyc_q;
    pi_d        = pi_q;
    pj_d        = pj_q;
    cur_d       = cur_q;
    cmp_vld_d   = 1'b0;
    clear_o     = 1'b0;
    res_vld_o   = 1'b0;
    rd_a_addr_o = cur_q;
    rd_b_addr_o = pj_q[IW-1:0];
    par_d       = par_q ^ (cmp_vld_q && (rd_a_data_i > rd_b_data_i));
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        visited_d = '0;
        i_d       = '0;
        cyc_d     = '0;
        par_d     = 1'b0;
        state_d   = acc_i.bad ? S_DONE : S_OUTER;
      end
      S_OUTER: begin
        if (i_q == count_i) begin
          if (count_i < CW'(2)) begin
            state_d = S_DONE;
          end else begin
            pi_d    = '0;
            pj_d    = CW'(1);
            state_d = S_PAR;
          end
        end else if (visited_q[i_q[IW-1:0]]) begin
          i_d = i_q + CW'(1);
        end else begin
          cyc_d   = cyc_q + CW'(1);
          cur_d   = i_q[IW-1:0];
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        visited_d[cur_q] = 1'b1;
        state_d          = S_FOLLOW;
      end
      S_FOLLOW: begin
        if (visited_q[t_idx]) begin
          i_d     = i_q + CW'(1);
          state_d = S_OUTER;
        end else begin
          cur_d   = t_idx;
          state_d = S_MARK;
        end
      end
      S_PAR: begin
        rd_a_addr_o = pi_q[IW-1:0];
        cmp_vld_d   = 1'b1;
        if (pj_q == count_i - CW'(1)) begin
          if (pi_q == count_i - CW'(2)) begin
            state_d = S_PDRAIN;
          end else begin
            pi_d = pi_q + CW'(1);
            pj_d = pi_q + CW'(2);
          end
        end else begin
          pj_d = pj_q + CW'(1);
        end
      end
      S_PDRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_free_i) begin
          res_vld_o = 1'b1;
          clear_o   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Combine the bounds and apply the parity correction, or report a bad input.
  always_comb begin
    diff_w    = SW'(count_i - cyc_q);
    cyc_bound = (diff_w > SW'(15)) ? 4'hF : diff_w[CycW-1:0];
    half      = (8'(acc_i.dist_sum) + 8'd1) >> 1;
    bound_a   = (8'(acc_i.dist_max) > half) ? 8'(acc_i.dist_max) : half;
    bound_b   = (8'(cyc_bound) > bound_a) ? 8'(cyc_bound) : bound_a;
    bound_c   = (bound_b[0] != par_q) ? bound_b + 8'd1 : bound_b;
    if (acc_i.bad) begin
      res_o           = '0;
      res_o.bad_input = 1'b1;
    end else begin
      res_o.total_hamming    = acc_i.dist_sum;
      res_o.max_hamming      = acc_i.dist_max;
      res_o.cycle_bound      = cyc_bound;
      res_o.inversion_parity = par_q;
      res_o.swap_bound       = (bound_c > 8'd63) ? 6'd63 : bound_c[BoundW-1:0];
      res_o.bad_input        = 1'b0;
    end
  end

  assign idle_o = (state_q == S_IDLE);

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      visited_q <= '0;
      i_q       <= '0;
      cyc_q     <= '0;
      pi_q      <= '0;
      pj_q      <= '0;
      cur_q     <= '0;
      par_q     <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      i_q       <= i_d;
      cyc_q     <= cyc_d;
      pi_q      <= pi_d;
      pj_q      <= pj_d;
      cur_q     <= cur_d;
      par_q     <= par_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

endmodule

/* verif/tb_permutation_swap_lower_bound_core.sv */
// Self-checking testbench for the permutation swap lower bound core.
module tb_permutation_swap_lower_bound_core;
  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;

  localparam int unsigned NodeCap    = MaxNodesDefault;
  localparam int unsigned ItemTarget = 1000;
  localparam int unsigned QuietTail  = 150;
  localparam int unsigned MaxReports = 10;

  // Results that can be read off directly.
  localparam psl_res_t NoCheck      = '0;
  localparam psl_res_t ResSingle    = '{7'd0, 3'd0, 4'd0, 1'b0, 6'd0, 1'b0};
  localparam psl_res_t ResBadToken  = '{7'd0, 3'd0, 4'd0, 1'b0, 6'd0, 1'b1};
  localparam psl_res_t ResSwapPair  = '{7'd2, 3'd1, 4'd1, 1'b1, 6'd1, 1'b0};
  localparam psl_res_t ResReverse16 = '{7'd64, 3'd4, 4'd8, 1'b0, 6'd32, 1'b0};

  typedef struct {
    logic [TokW-1:0] tok;
    logic            last;
    bit              typed;
    psl_res_t        res;
  } dir_row_t;

  // Directed rows: single node, out-of-range token, one swap, full reversal
  // of 16 nodes (largest distances), and a run of repeated tokens.
  localparam int unsigned DirRows = 23;
  dir_row_t dir_rows [DirRows] = '{
    '{4'd0,  1'b1, 1'b1, ResSingle},
    '{4'd5,  1'b1, 1'b1, ResBadToken},
    '{4'd1,  1'b0, 1'b0, NoCheck},
    '{4'd0,  1'b1, 1'b1, ResSwapPair},
    '{4'd15, 1'b0, 1'b0, NoCheck},
    '{4'd14, 1'b0, 1'b0, NoCheck},
    '{4'd13, 1'b0, 1'b0, NoCheck},
    '{4'd12, 1'b0, 1'b0, NoCheck},
    '{4'd11, 1'b0, 1'b0, NoCheck},
    '{4'd10, 1'b0, 1'b0, NoCheck},
    '{4'd9,  1'b0, 1'b0, NoCheck},
    '{4'd8,  1'b0, 1'b0, NoCheck},
    '{4'd7,  1'b0, 1'b0, NoCheck},
    '{4'd6,  1'b0, 1'b0, NoCheck},
    '{4'd5,  1'b0, 1'b0, NoCheck},
    '{4'd4,  1'b0, 1'b0, NoCheck},
    '{4'd3,  1'b0, 1'b0, NoCheck},
    '{4'd2,  1'b0, 1'b0, NoCheck},
    '{4'd1,  1'b0, 1'b0, NoCheck},
    '{4'd0,  1'b1, 1'b1, ResReverse16},
    '{4'd1,  1'b0, 1'b0, NoCheck},
    '{4'd1,  1'b0, 1'b0, NoCheck},
    '{4'd1,  1'b1, 1'b0, NoCheck}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [TokW-1:0]    token_i;
  logic               last_token_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [TotW-1:0]    total_hamming_o;
  logic [DmaxW-1:0]   max_hamming_o;
  logic [CycW-1:0]    cycle_bound_o;
  logic               inversion_parity_o;
  logic [BoundW-1:0]  swap_bound_o;
  logic               bad_input_o;

  // Predictor state: the permutation loaded so far and its running totals.
  logic [TokW-1:0] perm_tokens [NodeCap];
  int unsigned     perm_len;
  int unsigned     ham_total;
  int unsigned     ham_peak;
  bit              perm_err;

  psl_res_t    pending_bounds [$];
  int unsigned fail_count;
  int unsigned random_beats;
  bit          quiet;
  psl_res_t    seen_res;
  psl_res_t    want_res;

  permutation_swap_lower_bound_core #(
    .MAX_NODES(NodeCap)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .token_i,
    .last_token_i,
    .out_valid_o,
    .out_ready_i,
    .total_hamming_o,
    .max_hamming_o,
    .cycle_bound_o,
    .inversion_parity_o,
    .swap_bound_o,
    .bad_input_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Fold one accepted token into the predicted permutation; a closing beat
  // yields the bounds and clears the loader.
  task automatic fold_token(input logic [TokW-1:0] tok, input logic last,
                            output bit has_res, output psl_res_t res);
    int unsigned node_dist;
    int unsigned n;
    int unsigned cycles;
    int unsigned cyc;
    int unsigned par;
    int unsigned bound;
    int unsigned cur;
    bit          marked [NodeCap];
    has_res = 1'b0;
    res = '0;
    if (perm_len < NodeCap) begin
      node_dist = $countones(perm_len ^ int'(tok));
      perm_tokens[perm_len] = tok;
      perm_len++;
      ham_total = (ham_total + node_dist > 127) ? 127 : ham_total + node_dist;
      if (node_dist > 7) node_dist = 7;
      if (node_dist > ham_peak) ham_peak = node_dist;
    end else begin
      perm_err = 1'b1;
    end
    if (!last) return;
    has_res = 1'b1;
    n = perm_len;
    for (int unsigned i = 0; i < n; i++) begin
      if (perm_tokens[i] >= n) perm_err = 1'b1;
    end
    if (perm_err) begin
      res.bad_input = 1'b1;
    end else begin
      // Walk each cycle of the permutation, stopping at a visited node.
      foreach (marked[i]) marked[i] = 1'b0;
      cycles = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (!marked[i]) begin
          cycles++;
          cur = i;
          while (cur < n && !marked[cur]) begin
            marked[cur] = 1'b1;
            cur = perm_tokens[cur];
          end
        end
      end
      cyc = (n - cycles > 15) ? 15 : n - cycles;
      par = 0;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = i + 1; j < n; j++) begin
          if (perm_tokens[i] > perm_tokens[j]) par ^= 1;
        end
      end
      bound = (ham_total + 1) / 2;
      if (ham_peak > bound) bound = ham_peak;
      if (cyc > bound) bound = cyc;
      if ((bound & 1) != par) bound++;
      if (bound > 63) bound = 63;
      res.total_hamming    = TotW'(ham_total);
      res.max_hamming      = DmaxW'(ham_peak);
      res.cycle_bound      = CycW'(cyc);
      res.inversion_parity = par[0];
      res.swap_bound       = BoundW'(bound);
    end
    perm_len  = 0;
    ham_total = 0;
    ham_peak  = 0;
    perm_err  = 1'b0;
  endtask

  // Offer one beat, called at a falling edge; returns at the falling edge
  // after acceptance with valid still high.
  task automatic send_beat(input logic [TokW-1:0] tok, input logic last,
                           input bit typed, input psl_res_t typed_res);
    bit       has_res;
    psl_res_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    token_i      = tok;
    last_token_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    fold_token(tok, last, has_res, predicted);
    if (has_res) begin
      pending_bounds.insert(pending_bounds.size(), typed ? typed_res : predicted);
    end
    @(negedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_bounds.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: stalls in short bursts, none in the quiet tail.
  initial begin
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        stall_left  = $urandom_range(0, 3);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = '{total_hamming_o, max_hamming_o, cycle_bound_o,
                   inversion_parity_o, swap_bound_o, bad_input_o};
      if (pending_bounds.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("ERROR: unexpected result beat tot=%0d max=%0d cyc=%0d par=%0d bnd=%0d bad=%0d",
                   seen_res.total_hamming, seen_res.max_hamming, seen_res.cycle_bound,
                   seen_res.inversion_parity, seen_res.swap_bound, seen_res.bad_input);
        end
      end else begin
        want_res = pending_bounds.pop_front();
        if (seen_res.total_hamming !== want_res.total_hamming ||
            seen_res.max_hamming !== want_res.max_hamming ||
            seen_res.cycle_bound !== want_res.cycle_bound ||
            seen_res.inversion_parity !== want_res.inversion_parity ||
            seen_res.swap_bound !== want_res.swap_bound ||
            seen_res.bad_input !== want_res.bad_input) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("ERROR: result mismatch at %0t", $realtime);
            $display("  expected tot=%0d max=%0d cyc=%0d par=%0d bnd=%0d bad=%0d",
                     want_res.total_hamming, want_res.max_hamming, want_res.cycle_bound,
                     want_res.inversion_parity, want_res.swap_bound, want_res.bad_input);
            $display("  actual   tot=%0d max=%0d cyc=%0d par=%0d bnd=%0d bad=%0d",
                     seen_res.total_hamming, seen_res.max_hamming, seen_res.cycle_bound,
                     seen_res.inversion_parity, seen_res.swap_bound, seen_res.bad_input);
          end
        end
      end
    end
  end

  // Main stimulus: reset, directed table, then random permutations.
  initial begin
    int unsigned    kind;
    int unsigned    n;
    int unsigned    pick;
    int unsigned    tmp;
    logic [TokW-1:0] seq [$];
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    token_i      = '0;
    last_token_i = 1'b0;
    perm_len     = 0;
    ham_total    = 0;
    ham_peak     = 0;
    perm_err     = 1'b0;
    fail_count   = 0;
    random_beats = 0;
    quiet        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].tok, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
    end
    drain_results();

    while (random_beats < ItemTarget) begin
      quiet = (random_beats + QuietTail >= ItemTarget);
      if (!quiet && $urandom_range(0, 29) == 0) drain_results();
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 3) == 0 || kind >= 90) ? NodeCap : $urandom_range(1, 10);
      // Shuffled identity of n nodes.
      seq.delete();
      for (int unsigned i = 0; i < n; i++) seq.insert(seq.size(), TokW'(i));
      for (int unsigned i = n - 1; i > 0; i--) begin
        pick = $urandom_range(0, i);
        tmp = seq[i];
        seq[i] = seq[pick];
        seq[pick] = TokW'(tmp);
      end
      if (kind >= 65 && kind < 80) begin
        // One corrupted token: a repeat or an out-of-range value.
        seq[$urandom_range(0, n - 1)] = TokW'($urandom_range(0, 15));
      end else if (kind >= 80 && kind < 90) begin
        foreach (seq[i]) seq[i] = TokW'($urandom_range(0, 15));
      end else if (kind >= 90 && kind < 97) begin
        // More beats than the store holds.
        repeat ($urandom_range(1, 4)) seq.insert(seq.size(), TokW'($urandom_range(0, 15)));
      end
      foreach (seq[i]) begin
        send_beat(seq[i], (i == seq.size() - 1), 1'b0, NoCheck);
        random_beats++;
      end
    end
    in_valid_i = 1'b0;

    while (pending_bounds.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
